// ===== rtl/nhe_pkg.sv =====
// types, constants and parity functions for the 512-byte nand hamming ecc unit
// no dependencies; used by nhe_check and nand_hamming_ecc_512_unit
`default_nettype none

package nhe_pkg;

  localparam int unsigned CODE_W  = 24;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned LINE_W  = 9;
  localparam int unsigned PAIRS   = 12;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [ADDR_W-1:0] REG_INVERT_CODE = 3'd0;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_CORRECTED = 2'd1;
  localparam status_t ST_UNCORR    = 2'd2;

  typedef struct packed {
    logic              mode;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [CODE_W-1:0] stored_ecc;
  } in_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] computed_ecc;
    status_t           status;
    logic              data_fix;
    logic [8:0]        error_byte;
    logic [2:0]        error_bit;
  } out_item_t;

  // six column parities plus row parity in bit 6
  function automatic logic [COL_W-1:0] byte_code(input logic [7:0] v);
    logic [COL_W-1:0] c;
    c = '0;
    for (int b = 0; b < 8; b++) begin
      for (int k = 0; k < 3; k++) begin
        if (((b >> k) & 1) != 0) begin
          c[2*k+1] = c[2*k+1] ^ v[b];
        end else begin
          c[2*k] = c[2*k] ^ v[b];
        end
      end
      c[6] = c[6] ^ v[b];
    end
    return c;
  endfunction

  // expand line bits into pairs and append the column bits
  function automatic logic [CODE_W-1:0] build_code(input logic [COL_W-1:0] col,
                                                   input logic [LINE_W-1:0] lines);
    logic [CODE_W-1:0] code;
    code = '0;
    code[5:0] = col[5:0];
    for (int i = 0; i < LINE_W; i++) begin
      code[6+2*i]   = lines[i] ^ col[6];
      code[6+2*i+1] = lines[i];
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/nhe_check.sv =====
// final code assembly and comparison with the stored code for one block
// depends on nhe_pkg
`default_nettype none

module nhe_check (
  input  wire logic [nhe_pkg::COL_W-1:0]  col,
  input  wire logic [nhe_pkg::LINE_W-1:0] lines,
  input  wire logic                       invert,
  input  wire logic                       mode,
  input  wire logic [nhe_pkg::CODE_W-1:0] stored_ecc,
  output nhe_pkg::out_item_t              result
);

  logic [nhe_pkg::CODE_W-1:0] code;
  logic [nhe_pkg::CODE_W-1:0] diff;
  logic [4:0]                 ones;
  logic                       all_split;
  logic [nhe_pkg::PAIRS-1:0]  pos;

  always_comb begin
    code = nhe_pkg::build_code(col, lines);
    if (invert) begin
      code = ~code;
    end
    diff = code ^ stored_ecc;
    ones = 5'($countones(diff));
    all_split = 1'b1;
    for (int i = 0; i < nhe_pkg::PAIRS; i++) begin
      all_split = all_split & (diff[2*i] ^ diff[2*i+1]);
      pos[i]    = diff[2*i+1];
    end

    result              = '0;
    result.computed_ecc = code;
    if (mode) begin
      if (ones == 5'd0) begin
        result.status = nhe_pkg::ST_OK;
      end else if (ones == 5'd1) begin
        result.status = nhe_pkg::ST_CORRECTED;
      end else if (all_split) begin
        // data bit error: every pair differs in exactly one bit
        result.status     = nhe_pkg::ST_CORRECTED;
        result.data_fix   = 1'b1;
        result.error_byte = pos[11:3];
        result.error_bit  = pos[2:0];
      end else begin
        result.status = nhe_pkg::ST_UNCORR;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nand_hamming_ecc_512_unit.sv =====
// nand hamming ecc unit: 24-bit code over a 512-byte block, one byte per item
// the result is registered and shown in the cycle after the last byte of a block is accepted
// throughput: one byte per cycle; parity update and code check fit between byte and result register
// a byte is taken while a result waits only if the result register frees in the same cycle
// reset clears parities, byte counter and result valid; invert_code resets to 1
// depends on nhe_pkg and nhe_check
`default_nettype none

module nand_hamming_ecc_512_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               byte_valid,
  output logic                                    byte_ready,
  input  wire nhe_pkg::in_item_t                  byte_item,
  output logic                                    ecc_valid,
  input  wire logic                               ecc_ready,
  output nhe_pkg::out_item_t                      ecc_item,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [nhe_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [nhe_pkg::DATA_W-1:0]         pwdata,
  output logic [nhe_pkg::DATA_W-1:0]              prdata,
  output logic                                    pready
);

  logic                        invert_code;
  logic [nhe_pkg::COL_W-1:0]   column_parity;
  logic [nhe_pkg::LINE_W-1:0]  line_parity;
  logic [8:0]                  byte_count;
  logic [nhe_pkg::COL_W-1:0]   column_parity_next;
  logic [nhe_pkg::LINE_W-1:0]  line_parity_next;
  logic [nhe_pkg::COL_W-1:0]   code_of_byte;
  logic                        byte_fire;
  nhe_pkg::out_item_t          result;

  assign pready     = 1'b1;
  assign byte_ready = !ecc_valid || ecc_ready;
  assign byte_fire  = byte_valid && byte_ready;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_code <= 1'b1;
    end else if (psel && penable && pwrite && paddr == nhe_pkg::REG_INVERT_CODE) begin
      invert_code <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == nhe_pkg::REG_INVERT_CODE) begin
      prdata[0] = invert_code;
    end
  end

  // parity accumulation
  always_comb begin
    code_of_byte       = nhe_pkg::byte_code(byte_item.data_byte);
    column_parity_next = column_parity ^ code_of_byte;
    line_parity_next   = line_parity;
    if (code_of_byte[6]) begin
      line_parity_next = line_parity ^ byte_count;
    end
  end

  nhe_check u_check (
    .col        (column_parity_next),
    .lines      (line_parity_next),
    .invert     (invert_code),
    .mode       (byte_item.mode),
    .stored_ecc (byte_item.stored_ecc),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      column_parity <= '0;
      line_parity   <= '0;
      byte_count    <= '0;
    end else if (byte_fire) begin
      if (byte_item.last_byte) begin
        column_parity <= '0;
        line_parity   <= '0;
        byte_count    <= '0;
      end else begin
        column_parity <= column_parity_next;
        line_parity   <= line_parity_next;
        byte_count    <= byte_count + 9'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ecc_valid <= 1'b0;
    end else if (byte_fire && byte_item.last_byte) begin
      ecc_valid <= 1'b1;
    end else if (ecc_ready) begin
      ecc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_fire && byte_item.last_byte) begin
      ecc_item <= result;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    byte_fire && byte_item.last_byte |=> byte_count == 9'd0 && column_parity == '0
      && line_parity == '0)
    else $error("block state not cleared after last byte");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    byte_fire && !byte_item.last_byte |=> byte_count == $past(byte_count) + 9'd1)
    else $error("byte counter did not advance");

  a_result_shown: assert property (@(posedge clk) disable iff (rst)
    byte_fire && byte_item.last_byte |=> ecc_valid)
    else $error("no result after last byte");

  a_gen_mode_clean: assert property (@(posedge clk) disable iff (rst)
    byte_fire && byte_item.last_byte && !byte_item.mode |=>
      ecc_item.status == nhe_pkg::ST_OK && !ecc_item.data_fix)
    else $error("status set in generate mode");

  a_fix_only_corrected: assert property (@(posedge clk) disable iff (rst)
    ecc_valid && ecc_item.data_fix |-> ecc_item.status == nhe_pkg::ST_CORRECTED)
    else $error("data fix without corrected status");

endmodule

`default_nettype wire

// ===== sim/nand_hamming_ecc_512_unit_test.sv =====
// testbench for nand_hamming_ecc_512_unit: directed and random byte blocks with generate and check
// items, predicted by a scoreboard class; depends on nhe_pkg and the unit's rtl

module nand_hamming_ecc_512_unit_test;

  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 300;

  typedef enum int {
    BLK_GEN_ONLY,
    BLK_EXACT,
    BLK_CODE_BIT,
    BLK_DATA_BIT,
    BLK_BAD_PAIR,
    BLK_SCRAMBLE
  } block_kind_t;

  class ecc_scoreboard;
    logic [nhe_pkg::COL_W-1:0]  col_par;
    logic [nhe_pkg::LINE_W-1:0] line_par;
    logic [8:0]                 byte_pos;
    bit                         invert;
    nhe_pkg::out_item_t         block_results[$];
    int mismatches, checked, bytes, blocks, checks, data_fixes, code_fixes, uncorr;

    function new();
      invert = 1'b1;
      col_par = '0;
      line_par = '0;
      byte_pos = '0;
    endfunction

    function logic [nhe_pkg::COL_W-1:0] parity_bits(logic [7:0] v);
      return {^v, ^(v & 8'hF0), ^(v & 8'h0F), ^(v & 8'hCC), ^(v & 8'h33),
              ^(v & 8'hAA), ^(v & 8'h55)};
    endfunction

    function logic [nhe_pkg::CODE_W-1:0] lay_out_code(logic [nhe_pkg::COL_W-1:0] col,
                                                      logic [nhe_pkg::LINE_W-1:0] lines);
      logic [nhe_pkg::CODE_W-1:0] c;
      c = '0;
      c[5:0] = col[5:0];
      for (int i = 0; i < nhe_pkg::LINE_W; i++) begin
        c[7 + 2*i] = lines[i];
        c[6 + 2*i] = lines[i] ^ col[6];
      end
      return invert ? ~c : c;
    endfunction

    // code the block would get if this byte closed it
    function logic [nhe_pkg::CODE_W-1:0] code_if_last(logic [7:0] v);
      logic [nhe_pkg::COL_W-1:0] pb;
      pb = parity_bits(v);
      return lay_out_code(col_par ^ pb, pb[6] ? (line_par ^ byte_pos) : line_par);
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_byte(nhe_pkg::in_item_t it);
      logic [nhe_pkg::COL_W-1:0]  pb;
      logic [nhe_pkg::CODE_W-1:0] d;
      logic [11:0]                pos;
      bit                         bad;
      nhe_pkg::out_item_t         r;
      pb = parity_bits(it.data_byte);
      bytes++;
      if (pb[6]) line_par ^= byte_pos;
      col_par ^= pb;
      byte_pos++;
      if (!it.last_byte) return;
      r = '0;
      r.computed_ecc = lay_out_code(col_par, line_par);
      r.status = nhe_pkg::ST_OK;
      if (it.mode) begin
        checks++;
        d = r.computed_ecc ^ it.stored_ecc;
        case ($countones(d))
          0: ;
          1: begin
            r.status = nhe_pkg::ST_CORRECTED;
            code_fixes++;
          end
          12: begin
            bad = 1'b0;
            pos = '0;
            for (int i = 0; i < nhe_pkg::PAIRS; i++) begin
              case (d[2*i +: 2])
                2'b10: pos[i] = 1'b1;
                2'b01: pos[i] = 1'b0;
                default: bad = 1'b1;
              endcase
            end
            if (bad) begin
              r.status = nhe_pkg::ST_UNCORR;
              uncorr++;
            end else begin
              r.status = nhe_pkg::ST_CORRECTED;
              r.data_fix = 1'b1;
              r.error_byte = pos[11:3];
              r.error_bit = pos[2:0];
              data_fixes++;
            end
          end
          default: begin
            r.status = nhe_pkg::ST_UNCORR;
            uncorr++;
          end
        endcase
      end
      block_results.push_back(r);
      blocks++;
      col_par = '0;
      line_par = '0;
      byte_pos = '0;
    endfunction

    function void check_result(nhe_pkg::out_item_t got);
      nhe_pkg::out_item_t want;
      checked++;
      if (block_results.size() == 0) begin
        complain($sformatf("result with no block pending: ecc %06h status %0d",
                           got.computed_ecc, got.status));
        return;
      end
      want = block_results.pop_front();
      if (got.computed_ecc !== want.computed_ecc || got.status !== want.status ||
          got.data_fix !== want.data_fix || got.error_byte !== want.error_byte ||
          got.error_bit !== want.error_bit) begin
        complain($sformatf({"expected ecc %06h st %0d fix %0d byte %0d bit %0d, ",
                            "got ecc %06h st %0d fix %0d byte %0d bit %0d"},
                           want.computed_ecc, want.status, want.data_fix, want.error_byte,
                           want.error_bit, got.computed_ecc, got.status, got.data_fix,
                           got.error_byte, got.error_bit));
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        byte_valid = 1'b0;
  logic                        byte_ready;
  nhe_pkg::in_item_t           byte_item = '0;
  logic                        ecc_valid;
  logic                        ecc_ready = 1'b0;
  nhe_pkg::out_item_t          ecc_item;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [nhe_pkg::ADDR_W-1:0]  paddr = '0;
  logic [nhe_pkg::DATA_W-1:0]  pwdata = '0;
  logic [nhe_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  ecc_scoreboard board;
  bit            calm;
  int            stall_cycles;

  nand_hamming_ecc_512_unit DUT (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_ready(byte_ready), .byte_item(byte_item),
    .ecc_valid(ecc_valid), .ecc_ready(ecc_ready), .ecc_item(ecc_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // code difference that, xored onto the code, makes the checker point at data bit pos
  function logic [nhe_pkg::CODE_W-1:0] data_syndrome(logic [11:0] pos);
    logic [nhe_pkg::CODE_W-1:0] s;
    for (int i = 0; i < nhe_pkg::PAIRS; i++) s[2*i +: 2] = pos[i] ? 2'b10 : 2'b01;
    return s;
  endfunction

  task write_reg(input logic [nhe_pkg::ADDR_W-1:0] addr,
                 input logic [nhe_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task read_reg(input logic [nhe_pkg::ADDR_W-1:0] addr,
                output logic [nhe_pkg::DATA_W-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task drain_results();
    byte_valid <= 1'b0;
    while (board.block_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_invert(input bit v);
    logic [nhe_pkg::DATA_W-1:0] rd;
    drain_results();
    write_reg(nhe_pkg::ADDR_W'(4 * nhe_pkg::REG_INVERT_CODE), nhe_pkg::DATA_W'(v));
    board.invert = v;
    @(posedge clk);
    read_reg(nhe_pkg::ADDR_W'(4 * nhe_pkg::REG_INVERT_CODE), rd);
    if (rd !== nhe_pkg::DATA_W'(v)) begin
      board.complain($sformatf("invert_code reads %0h, wrote %0d", rd, v));
    end
  endtask

  task push_byte(input nhe_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_item <= it;
    byte_valid <= 1'b1;
    do @(posedge clk); while (!byte_ready);
    board.note_byte(it);
  endtask

  // fill and sel < 0 mean random
  task send_block(input int len, input block_kind_t kind, input int fill, input int sel);
    nhe_pkg::in_item_t          it;
    logic [nhe_pkg::CODE_W-1:0] code;
    logic [nhe_pkg::CODE_W-1:0] s;
    int                         a;
    int                         b;
    for (int i = 0; i < len; i++) begin
      it.data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
      it.mode = 1'($urandom);
      it.stored_ecc = nhe_pkg::CODE_W'($urandom);
      it.last_byte = (i == len - 1);
      if (it.last_byte) begin
        code = board.code_if_last(it.data_byte);
        it.mode = (kind != BLK_GEN_ONLY);
        case (kind)
          BLK_EXACT: it.stored_ecc = code;
          BLK_CODE_BIT: begin
            a = (sel < 0) ? $urandom_range(0, nhe_pkg::CODE_W - 1) : sel;
            it.stored_ecc = code ^ (nhe_pkg::CODE_W'(1) << a);
          end
          BLK_DATA_BIT: begin
            it.stored_ecc = code ^ data_syndrome((sel < 0) ? 12'($urandom) : 12'(sel));
          end
          BLK_BAD_PAIR: begin
            s = data_syndrome(12'($urandom));
            a = $urandom_range(0, nhe_pkg::PAIRS - 1);
            b = (a + $urandom_range(1, nhe_pkg::PAIRS - 1)) % nhe_pkg::PAIRS;
            s[2*a +: 2] = 2'b11;
            s[2*b +: 2] = 2'b00;
            it.stored_ecc = code ^ s;
          end
          BLK_SCRAMBLE: begin
            it.stored_ecc = code ^ ((sel < 0) ? nhe_pkg::CODE_W'($urandom)
                                              : nhe_pkg::CODE_W'(sel));
          end
          default: ;
        endcase
      end
      push_byte(it);
    end
  endtask

  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (ecc_valid && ecc_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("no item moved for %0d cycles", STALL_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random ready gaps plus one long hold so the unit backs up
  initial begin
    int g;
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      if (!held && board.checked == 16) begin
        held = 1'b1;
        ecc_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      g = pick_gap();
      if (g > 0) begin
        ecc_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      ecc_ready <= 1'b1;
      do @(posedge clk); while (!ecc_valid);
      board.check_result(ecc_item);
    end
  end

  initial begin
    logic [nhe_pkg::DATA_W-1:0] rd;
    int                         len;
    int                         r;
    int                         n_items;
    int                         n_blocks;
    block_kind_t                kind;
    board = new();
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    read_reg(nhe_pkg::ADDR_W'(4 * nhe_pkg::REG_INVERT_CODE), rd);
    if (rd !== nhe_pkg::DATA_W'(1)) board.complain($sformatf("invert_code resets to %0h", rd));
    @(posedge clk);

    // directed: extremes, each error class, short blocks
    send_block(1, BLK_GEN_ONLY, 8'h00, -1);
    send_block(1, BLK_EXACT, 8'hFF, -1);
    send_block(1, BLK_CODE_BIT, 8'h01, nhe_pkg::CODE_W - 1);
    send_block(1, BLK_DATA_BIT, 8'h80, 0);
    set_invert(1'b0);
    send_block(1, BLK_DATA_BIT, 8'h5A, 12'hFFF);
    send_block(1, BLK_BAD_PAIR, 8'h33, -1);
    send_block(1, BLK_SCRAMBLE, 8'hC3, 24'hFFFFFF);
    send_block(1, BLK_SCRAMBLE, 8'h0F, 3);
    send_block(1, BLK_CODE_BIT, 8'hAA, 0);
    send_block(2, BLK_GEN_ONLY, -1, -1);
    send_block(3, BLK_EXACT, 8'hFF, -1);

    // random: one over-length block that runs through every position, short blocks otherwise
    for (int ph = 0; ph < 4; ph++) begin
      set_invert(ph % 2 == 0);
      n_items = 0;
      n_blocks = 0;
      while (n_items < 80 || n_blocks < 10) begin
        if ($urandom_range(0, 5) == 0) calm = !calm;
        if (ph == 1 && n_blocks == 0) begin
          len = $urandom_range(513, 530);
        end else if ($urandom_range(0, 3) == 0) begin
          len = $urandom_range(9, 40);
        end else begin
          len = $urandom_range(1, 8);
        end
        r = $urandom_range(0, 99);
        kind = (r < 20) ? BLK_GEN_ONLY : (r < 40) ? BLK_EXACT : (r < 55) ? BLK_CODE_BIT :
               (r < 80) ? BLK_DATA_BIT : (r < 88) ? BLK_BAD_PAIR : BLK_SCRAMBLE;
        send_block(len, kind, -1, -1);
        n_items += len;
        n_blocks++;
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("%0d bytes in %0d blocks, code inverted and plain, lengths 1 to over 512",
             board.bytes, board.blocks);
    $display("%0d checks: %0d data bit fixes, %0d code bit fixes, %0d uncorrectable",
             board.checks, board.data_fixes, board.code_fixes, board.uncorr);
    if (board.mismatches == 0 && board.block_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.block_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/nhe_pkg.sv
rtl/nhe_check.sv
rtl/nand_hamming_ecc_512_unit.sv
sim/nand_hamming_ecc_512_unit_test.sv
